FILE: rtl/raster_block_rle_decoder_core_assert.svh
// Assertion macros for the raster block run-length decoder.
`ifndef RASTER_BLOCK_RLE_DECODER_CORE_ASSERT_SVH
`define RASTER_BLOCK_RLE_DECODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is low.
`define RBRLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbrle assertion failed");
// Next-cycle implication, disabled while reset is low.
`define RBRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbrle assertion failed");
`else
`define RBRLE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RBRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/rbrle_pkg.sv
// Shared types, codes and constants of the raster block run-length decoder.
package rbrle_pkg;

    localparam int MAX_DIM_DEFAULT = 256;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE = 2'd2;

    localparam logic [8:0]  BLOCK_WIDTH_RST  = 9'd256;
    localparam logic [8:0]  BLOCK_HEIGHT_RST = 9'd4;
    localparam logic [31:0] NODATA_VALUE_RST = 32'h8000_0001;

    // Parser phases
    localparam logic [2:0] PH_SIZE_HI   = 3'd0;
    localparam logic [2:0] PH_SIZE_LO   = 3'd1;
    localparam logic [2:0] PH_TYPE      = 3'd2;
    localparam logic [2:0] PH_MINLEN    = 3'd3;
    localparam logic [2:0] PH_MIN_FIRST = 3'd4;
    localparam logic [2:0] PH_MIN_REST  = 3'd5;
    localparam logic [2:0] PH_MARKER    = 3'd6;
    localparam logic [2:0] PH_PAYLOAD   = 3'd7;

    // Block type codes
    localparam logic [7:0] TYPE_RAW     = 8'h08;
    localparam logic [7:0] TYPE_LITERAL = 8'hD7;
    localparam logic [7:0] TYPE_MINRUN  = 8'hDF;
    localparam logic [7:0] TYPE_VALRUN  = 8'hE0;

    localparam logic [7:0] TOP_MASK   = 8'h7F;
    localparam logic [7:0] MARKER_MID = 8'd128;
    localparam logic [8:0] MARKER_SPAN = 9'd256;

    typedef struct packed {
        logic       empty_block;
        logic       block_start;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic        format_error;
        logic        block_last;
        logic        is_nodata;
        logic [16:0] run_length;
        logic [31:0] pixel_value;
    } t_result;

endpackage

FILE: rtl/raster_block_rle_decoder_core.sv
// A byte taken into the input register yields its run, if any, in the result register.
// Throughput: one byte per cycle; the parser step sits between the input
// register and the result register, and both stall only on m_axis_tready.
// Reset: synchronous, active low; clears both valid flags, the parse state
// (waiting for a block) and loads the configuration defaults.
module raster_block_rle_decoder_core #(
    parameter int MAX_DIM = rbrle_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input bytes
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0]                       s_axis_tuser,  // [0] block_start, [1] empty_block
    // Output runs
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [55:0]                      m_axis_tdata,  // [31:0] pixel_value,
                                                            // [48:32] run_length, zero pad
    output logic [1:0]                       m_axis_tuser,  // [0] is_nodata, [1] format_error
    output logic                             m_axis_tlast,  // block_last
    // Configuration writes
    input  logic                             i_cfg_we,
    input  logic [rbrle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbrle_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    localparam int PW = $clog2(MAX_DIM * MAX_DIM + 1);

    logic               r_in_valid;
    rbrle_pkg::t_item   r_in_item;
    logic               r_out_valid;
    rbrle_pkg::t_result r_out;
    logic               proc_go;
    logic [PW-1:0]      total;
    logic [31:0]        nodata;
    logic               res_valid;
    rbrle_pkg::t_result res;

    assign proc_go       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_go;

    rbrle_cfg #(
        .MAX_DIM (MAX_DIM),
        .PW      (PW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_total     (total),
        .o_nodata    (nodata)
    );

    rbrle_parse #(
        .PW (PW)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (proc_go),
        .i_item      (r_in_item),
        .i_total     (total),
        .i_nodata    (nodata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Input register: load on transfer, drop once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.data_byte   <= s_axis_tdata;
            r_in_item.block_start <= s_axis_tuser[0];
            r_in_item.empty_block <= s_axis_tuser[1];
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.run_length, r_out.pixel_value};
    assign m_axis_tuser  = {r_out.format_error, r_out.is_nodata};
    assign m_axis_tlast  = r_out.block_last;

`include "raster_block_rle_decoder_core_assert.svh"

    // An error run always closes its block
    `RBRLE_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
    // Input side stalls only behind a stalled result
    `RBRLE_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    // A byte that cannot advance stays in the input register
    `RBRLE_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !proc_go, r_in_valid)

endmodule

FILE: rtl/rbrle_cfg.sv
// Configuration registers and clamped block pixel count.
module rbrle_cfg #(
    parameter int MAX_DIM = rbrle_pkg::MAX_DIM_DEFAULT,
    parameter int PW      = 17
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rbrle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbrle_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic [PW-1:0]                    o_total,
    output logic [31:0]                      o_nodata
);
    localparam int DW = $clog2(MAX_DIM + 1);

    logic [8:0]    r_block_width;
    logic [8:0]    r_block_height;
    logic [31:0]   r_nodata_value;
    logic [DW-1:0] w_dim;
    logic [DW-1:0] h_dim;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_width  <= rbrle_pkg::BLOCK_WIDTH_RST;
            r_block_height <= rbrle_pkg::BLOCK_HEIGHT_RST;
            r_nodata_value <= rbrle_pkg::NODATA_VALUE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbrle_pkg::CFG_BLOCK_WIDTH:  r_block_width  <= i_cfg_wdata[8:0];
                rbrle_pkg::CFG_BLOCK_HEIGHT: r_block_height <= i_cfg_wdata[8:0];
                rbrle_pkg::CFG_NODATA_VALUE: r_nodata_value <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Clamp each dimension to 1..MAX_DIM
    always_comb begin
        if (r_block_width == 9'd0)
            w_dim = DW'(1);
        else if (32'(r_block_width) > 32'(MAX_DIM))
            w_dim = DW'(MAX_DIM);
        else
            w_dim = DW'(r_block_width);

        if (r_block_height == 9'd0)
            h_dim = DW'(1);
        else if (32'(r_block_height) > 32'(MAX_DIM))
            h_dim = DW'(MAX_DIM);
        else
            h_dim = DW'(r_block_height);
    end

    assign o_total  = PW'(w_dim) * PW'(h_dim);
    assign o_nodata = r_nodata_value;

endmodule

FILE: rtl/rbrle_parse.sv
// Block parser: header and body state, one byte per transfer, run clipping.
module rbrle_parse #(
    parameter int PW = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  rbrle_pkg::t_item   i_item,
    input  logic [PW-1:0]      i_total,
    input  logic [31:0]        i_nodata,
    output logic               o_res_valid,
    output rbrle_pkg::t_result o_res
);
    localparam int LW = (PW > 9) ? PW : 9;

    logic [2:0]    r_phase,      n_phase;
    logic [7:0]    r_type,       n_type;
    logic [7:0]    r_min_left,   n_min_left;
    logic [31:0]   r_min,        n_min;
    logic [6:0]    r_literal,    n_literal;
    logic [31:0]   r_accum,      n_accum;
    logic [1:0]    r_seen,       n_seen;
    logic [7:0]    r_pending,    n_pending;
    logic [PW-1:0] r_pd,         n_pd;
    logic          r_block_done, n_block_done;

    always_comb begin
        logic [7:0]    b;
        logic [7:0]    left_dec;
        logic [6:0]    lit_dec;
        logic [31:0]   accum_new;
        logic [2:0]    body_phase;
        logic          emit_req;
        logic [31:0]   emit_val;
        logic [8:0]    emit_len;
        logic          emit_all;
        logic          emit_nd;
        logic          emit_err;
        logic [PW-1:0] pd_base;
        logic [LW-1:0] rem;
        logic [LW-1:0] len_c;
        logic          clip;

        b          = i_item.data_byte;
        left_dec   = (r_min_left != 8'd0) ? r_min_left - 8'd1 : r_min_left;
        lit_dec    = (r_literal != 7'd0) ? r_literal - 7'd1 : r_literal;
        accum_new  = (r_seen == 2'd0) ? {24'd0, b & rbrle_pkg::TOP_MASK}
                                      : {r_accum[23:0], b};
        body_phase = (r_type == rbrle_pkg::TYPE_RAW) ? rbrle_pkg::PH_PAYLOAD
                                                     : rbrle_pkg::PH_MARKER;
        emit_req = 1'b0;
        emit_val = i_nodata;
        emit_len = 9'd1;
        emit_all = 1'b0;
        emit_nd  = 1'b0;
        emit_err = 1'b0;
        pd_base  = r_pd;
        rem      = '0;
        len_c    = '0;
        clip     = 1'b0;

        n_phase      = r_phase;
        n_type       = r_type;
        n_min_left   = r_min_left;
        n_min        = r_min;
        n_literal    = r_literal;
        n_accum      = r_accum;
        n_seen       = r_seen;
        n_pending    = r_pending;
        n_pd         = r_pd;
        n_block_done = r_block_done;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_item.empty_block || i_item.block_start) begin
            // Start a fresh block with cleared parse state; an empty block emits a nodata fill
            n_phase      = i_item.empty_block ? rbrle_pkg::PH_SIZE_HI
                                              : rbrle_pkg::PH_SIZE_LO;
            n_type       = '0;
            n_min_left   = '0;
            n_min        = '0;
            n_literal    = '0;
            n_accum      = '0;
            n_seen       = '0;
            n_pending    = '0;
            n_pd         = '0;
            pd_base      = '0;
            n_block_done = 1'b0;
            if (i_item.empty_block) begin
                emit_req = 1'b1;
                emit_all = 1'b1;
                emit_nd  = 1'b1;
            end
        end else if (!r_block_done) begin
            case (r_phase)
                rbrle_pkg::PH_SIZE_HI: n_phase = rbrle_pkg::PH_SIZE_LO;
                rbrle_pkg::PH_SIZE_LO: n_phase = rbrle_pkg::PH_TYPE;
                rbrle_pkg::PH_TYPE: begin
                    n_type  = b;
                    n_phase = rbrle_pkg::PH_MINLEN;
                end
                rbrle_pkg::PH_MINLEN: begin
                    n_min_left = b;
                    n_min      = '0;
                    n_phase    = (b == 8'd0) ? body_phase : rbrle_pkg::PH_MIN_FIRST;
                end
                rbrle_pkg::PH_MIN_FIRST: begin
                    n_min      = (r_type == rbrle_pkg::TYPE_VALRUN)
                                 ? {24'd0, b & rbrle_pkg::TOP_MASK} : {24'd0, b};
                    n_min_left = left_dec;
                    n_phase    = (left_dec == 8'd0) ? body_phase : rbrle_pkg::PH_MIN_REST;
                end
                rbrle_pkg::PH_MIN_REST: begin
                    n_min      = {r_min[23:0], b};
                    n_min_left = left_dec;
                    if (left_dec == 8'd0)
                        n_phase = body_phase;
                end
                rbrle_pkg::PH_MARKER: begin
                    if (r_type == rbrle_pkg::TYPE_VALRUN) begin
                        n_pending = b;
                        n_accum   = '0;
                        n_seen    = '0;
                        n_phase   = rbrle_pkg::PH_PAYLOAD;
                    end else if (r_type == rbrle_pkg::TYPE_MINRUN) begin
                        emit_req = (b != 8'd0);
                        emit_val = r_min;
                        emit_len = {1'b0, b};
                    end else if (r_type == rbrle_pkg::TYPE_LITERAL &&
                                 b < rbrle_pkg::MARKER_MID) begin
                        n_literal = b[6:0];
                        if (b != 8'd0)
                            n_phase = rbrle_pkg::PH_PAYLOAD;
                    end else if (b > rbrle_pkg::MARKER_MID) begin
                        // Nodata run of 256 minus the marker
                        emit_req = 1'b1;
                        emit_nd  = 1'b1;
                        emit_len = rbrle_pkg::MARKER_SPAN - {1'b0, b};
                    end else begin
                        // Bad marker: fill the rest of the block with nodata
                        emit_req = 1'b1;
                        emit_nd  = 1'b1;
                        emit_all = 1'b1;
                        emit_err = 1'b1;
                    end
                end
                rbrle_pkg::PH_PAYLOAD: begin
                    if (r_type == rbrle_pkg::TYPE_RAW) begin
                        emit_req = 1'b1;
                        emit_val = {24'd0, b} + r_min;
                    end else if (r_type == rbrle_pkg::TYPE_LITERAL) begin
                        n_literal = lit_dec;
                        if (lit_dec == 7'd0)
                            n_phase = rbrle_pkg::PH_MARKER;
                        emit_req = 1'b1;
                        emit_val = {24'd0, b} + r_min;
                    end else if (r_type == rbrle_pkg::TYPE_VALRUN) begin
                        n_accum = accum_new;
                        if (r_seen != 2'd3) begin
                            n_seen = r_seen + 2'd1;
                        end else begin
                            n_seen   = '0;
                            n_phase  = rbrle_pkg::PH_MARKER;
                            emit_req = (r_pending != 8'd0);
                            emit_val = accum_new + r_min;
                            emit_len = {1'b0, r_pending};
                        end
                    end else begin
                        n_phase = rbrle_pkg::PH_MARKER;
                    end
                end
                default: n_phase = rbrle_pkg::PH_SIZE_HI;
            endcase
        end

        // Clip the run at the block end
        if (emit_req) begin
            if (pd_base >= i_total) begin
                n_block_done = 1'b1;
            end else begin
                rem   = LW'(i_total) - LW'(pd_base);
                clip  = emit_all || (LW'(emit_len) > rem);
                len_c = clip ? rem : LW'(emit_len);
                n_pd  = pd_base + PW'(len_c);
                if (len_c == rem)
                    n_block_done = 1'b1;
                o_res_valid        = 1'b1;
                o_res.pixel_value  = emit_val;
                o_res.run_length   = 17'(len_c);
                o_res.is_nodata    = emit_nd;
                o_res.block_last   = (len_c == rem);
                o_res.format_error = (emit_err || clip) && !i_item.empty_block;
            end
        end
    end

    // Advance parse state on each processed transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= rbrle_pkg::PH_SIZE_HI;
            r_type       <= '0;
            r_min_left   <= '0;
            r_min        <= '0;
            r_literal    <= '0;
            r_accum      <= '0;
            r_seen       <= '0;
            r_pending    <= '0;
            r_pd         <= '0;
            r_block_done <= 1'b1;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_type       <= n_type;
            r_min_left   <= n_min_left;
            r_min        <= n_min;
            r_literal    <= n_literal;
            r_accum      <= n_accum;
            r_seen       <= n_seen;
            r_pending    <= n_pending;
            r_pd         <= n_pd;
            r_block_done <= n_block_done;
        end
    end

endmodule
